>>> rtl/hci_to_rgb_convert_core_defines.svh
// ----------------------------------------------------------------------------
// HCI to RGB converter assertion macros
// Shorthand for the concurrent checks on the converter ports.
// ----------------------------------------------------------------------------
`ifndef HCI_TO_RGB_CONVERT_CORE_DEFINES_SVH
`define HCI_TO_RGB_CONVERT_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define HCI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// implication with a fixed delay in cycles
`define HCI_ASSERT_LATER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("%m: delayed check failed");

`endif

>>> rtl/hci_pkg.sv
// ----------------------------------------------------------------------------
// HCI to RGB converter package
// Field widths, fixed-point constants and cosine series divisors.
// ----------------------------------------------------------------------------
package hci_pkg;

   localparam int IN_W      = 13;
   localparam int OUT_W     = 15;
   localparam int COS_W     = 32;
   localparam int FRAC_BITS = 12;
   localparam int LANES     = 3;

   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;

   localparam logic [IN_W-1:0] ONE_VALUE = IN_W'(1) << FRAC_BITS;

   // cosine in Q2.30
   localparam int          Q30_SHIFT   = 30;
   localparam logic [63:0] Q30_ONE     = 64'd1 << Q30_SHIFT;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int SERIES_LEN = 5;
   localparam int SERIES_DIV [SERIES_LEN] = '{132, 90, 56, 30, 12};

   // half of the 3 * 2^30 divisor, for round to nearest
   localparam logic [63:0] ROUND_BIAS = 64'd3 << (Q30_SHIFT - 1);

   // exact floor(n / 3) for n < 2^15: (n * 43691) >> 17
   localparam int DIV3_IN_W = 15;
   localparam int DIV3_M    = 43691;
   localparam int DIV3_M_W  = 16;
   localparam int DIV3_S    = 17;
   localparam int TERM_W    = 13;

   // accept edge to result strobe, in cycles
   localparam int LATENCY = 9;

endpackage

>>> rtl/hci_to_rgb_convert_core.sv
// ----------------------------------------------------------------------------
// HCI to RGB converter
// Converts hue, chroma and intensity pixels to signed fixed-point RGB.
// ----------------------------------------------------------------------------
// Use:
//   Drive req_hue, req_chroma and req_intensity with start high; the pixel is
//   taken at any rising edge where start is high and busy is low. busy is high
//   only while reset is held, so one pixel can be taken every cycle.
//   Each pixel gives one result: rsp_red, rsp_green, rsp_blue (Q.12, signed,
//   not clamped) and rsp_range_warning, shown for one cycle with rsp_valid.
//   Throughput is one pixel per cycle.
//   The path runs: hue wrap by reciprocal multiply, wrap subtract, per-channel
//   angle offset, quadrant fold, quarter-wave cosine ROM read, chroma multiply,
//   rounding shift, divide by three, intensity add. The ROM has 90 *
//   HUE_STEPS_PER_DEGREE + 1 entries and one read port per channel.
//   Reset empties the pipeline; pixels in flight are dropped. The receiver
//   has no way to stall the result channel, so nothing backs up.
// ----------------------------------------------------------------------------
module hci_to_rgb_convert_core #(
   parameter int HUE_STEPS_PER_DEGREE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [hci_pkg::IN_W-1:0]          req_hue,
   input  logic [hci_pkg::IN_W-1:0]          req_chroma,
   input  logic [hci_pkg::IN_W-1:0]          req_intensity,
   output logic                              rsp_valid,
   output logic signed [hci_pkg::OUT_W-1:0]  rsp_red,
   output logic signed [hci_pkg::OUT_W-1:0]  rsp_green,
   output logic signed [hci_pkg::OUT_W-1:0]  rsp_blue,
   output logic                              rsp_range_warning
);
   import hci_pkg::*;

   localparam int FULL    = 360 * HUE_STEPS_PER_DEGREE;
   localparam int THIRD   = 120 * HUE_STEPS_PER_DEGREE;
   localparam int QUARTER = 90 * HUE_STEPS_PER_DEGREE;
   localparam int ANG_W   = $clog2(FULL);
   localparam int U_W     = $clog2(QUARTER + 1);

   // floor(hue / FULL) as (hue * WRAP_M) >> WRAP_S, exact for IN_W-bit hue
   localparam int     WRAP_S   = IN_W + $clog2(FULL);
   localparam longint WRAP_M   = ((longint'(1) << WRAP_S) + longint'(FULL) - 1)
                                 / longint'(FULL);
   localparam int     WRAP_M_W = $clog2(WRAP_M + 1);
   localparam int     WRAP_P_W = IN_W + WRAP_M_W;
   localparam int     QUOT_MAX = ((1 << IN_W) - 1) / FULL;
   localparam int     QUOT_W   = (QUOT_MAX > 0) ? $clog2(QUOT_MAX + 1) : 1;

   localparam int PROD_W = IN_W + COS_W;
   localparam int DIV3_P_W = DIV3_IN_W + DIV3_M_W;
   localparam int PIPE_N = LATENCY - 1;

   localparam int LANE_OFS [LANES] = '{0, FULL - THIRD, THIRD};

   // shared pipeline: index s holds stage s + 1
   logic [PIPE_N-1:0] vld_ff;
   logic [PIPE_N-1:0] vld_in;
   logic [IN_W-1:0]   chroma_ff [PIPE_N];
   logic [IN_W-1:0]   inten_ff  [PIPE_N];
   logic              warn_ff   [PIPE_N];

   logic [IN_W-1:0]   hue1_ff;
   logic [QUOT_W-1:0] quot1_ff;
   logic [QUOT_W-1:0] quot1_in;
   logic [WRAP_P_W-1:0] wrap_prod;
   logic [IN_W-1:0]   wrap_sub;
   logic [ANG_W-1:0]  h2_ff;
   logic [ANG_W-1:0]  h2_in;
   logic              warn_in;
   logic              accept;

   logic [OUT_W-1:0]  ch_in [LANES];

   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  red_ff;
   logic [OUT_W-1:0]  green_ff;
   logic [OUT_W-1:0]  blue_ff;
   logic              rsp_warn_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   assign warn_in = (int'(req_hue) > FULL) || (req_chroma > ONE_VALUE)
                    || (req_intensity > ONE_VALUE);

   // stage 1: quotient of the hue wrap
   assign wrap_prod = WRAP_P_W'(req_hue) * WRAP_P_W'(WRAP_M);
   assign quot1_in  = QUOT_W'(wrap_prod >> WRAP_S);

   // stage 2: wrapped hue
   assign wrap_sub = IN_W'(int'(quot1_ff) * FULL);
   assign h2_in    = ANG_W'(hue1_ff - wrap_sub);

   assign vld_in = {vld_ff[PIPE_N-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[PIPE_N-1];
      end
   end

   always_ff @(posedge clock) begin
      chroma_ff[0] <= req_chroma;
      inten_ff[0]  <= req_intensity;
      warn_ff[0]   <= warn_in;
      hue1_ff      <= req_hue;
      quot1_ff     <= quot1_in;
      h2_ff        <= h2_in;
      for (int s = 1; s < PIPE_N; s++) begin
         chroma_ff[s] <= chroma_ff[s-1];
         inten_ff[s]  <= inten_ff[s-1];
         warn_ff[s]   <= warn_ff[s-1];
      end
      red_ff      <= ch_in[LANE_RED];
      green_ff    <= ch_in[LANE_GREEN];
      blue_ff     <= ch_in[LANE_BLUE];
      rsp_warn_ff <= warn_ff[PIPE_N-1];
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [ANG_W:0]                 ang_sum;
      logic [ANG_W-1:0]               ang3_ff;
      logic [ANG_W-1:0]               ang3_in;
      logic [ANG_W-1:0]               rem;
      logic                           odd;
      logic                           neg4_in;
      logic [U_W-1:0]                 u4_ff;
      logic [U_W-1:0]                 u4_in;
      logic                           neg4_ff;
      logic                           neg5_ff;
      logic signed [COS_W-1:0]        cos5;
      logic                           c_neg;
      logic [COS_W-2:0]               c_abs;
      logic [PROD_W-1:0]              prod6_ff;
      logic [PROD_W-1:0]              prod6_in;
      logic                           sign6_ff;
      logic [DIV3_IN_W-1:0]           n7_ff;
      logic                           sign7_ff;
      logic [DIV3_P_W-1:0]            div3_prod;
      logic [TERM_W-1:0]              q8_ff;
      logic                           sign8_ff;

      // stage 3: channel angle, one compare-subtract wraps it
      assign ang_sum = (ANG_W+1)'(h2_ff) + (ANG_W+1)'(LANE_OFS[l]);
      assign ang3_in = (ang_sum >= (ANG_W+1)'(FULL)) ? ANG_W'(ang_sum - (ANG_W+1)'(FULL))
                                                      : ANG_W'(ang_sum);

      // stage 4: fold into the first quadrant
      always_comb begin
         if (ang3_ff < ANG_W'(QUARTER)) begin
            rem     = ang3_ff;
            odd     = 1'b0;
            neg4_in = 1'b0;
         end else if (ang3_ff < ANG_W'(2 * QUARTER)) begin
            rem     = ang3_ff - ANG_W'(QUARTER);
            odd     = 1'b1;
            neg4_in = 1'b1;
         end else if (ang3_ff < ANG_W'(3 * QUARTER)) begin
            rem     = ang3_ff - ANG_W'(2 * QUARTER);
            odd     = 1'b0;
            neg4_in = 1'b1;
         end else begin
            rem     = ang3_ff - ANG_W'(3 * QUARTER);
            odd     = 1'b1;
            neg4_in = 1'b0;
         end
         u4_in = odd ? U_W'(ANG_W'(QUARTER) - rem) : U_W'(rem);
      end

      // stage 5: cosine lookup
      hci_cos_rom #(
         .QUARTER (QUARTER)
      ) u_cos_rom (
         .clock (clock),
         .addr  (u4_ff),
         .data  (cos5)
      );

      // stage 6: magnitude of 2 * chroma * cos, sign kept apart
      assign c_neg    = cos5[COS_W-1];
      assign c_abs    = c_neg ? (COS_W-1)'(-cos5) : (COS_W-1)'(cos5);
      assign prod6_in = PROD_W'({chroma_ff[4], 1'b0}) * PROD_W'(c_abs);

      // stage 8: divide by three
      assign div3_prod = DIV3_P_W'(n7_ff) * DIV3_P_W'(DIV3_M);

      // stage 9: add the term to intensity
      assign ch_in[l] = sign8_ff ? OUT_W'(inten_ff[7]) - OUT_W'(q8_ff)
                                 : OUT_W'(inten_ff[7]) + OUT_W'(q8_ff);

      always_ff @(posedge clock) begin
         ang3_ff  <= ang3_in;
         u4_ff    <= u4_in;
         neg4_ff  <= neg4_in;
         neg5_ff  <= neg4_ff;
         prod6_ff <= prod6_in;
         sign6_ff <= c_neg ^ neg5_ff;
         n7_ff    <= DIV3_IN_W'((prod6_ff + PROD_W'(ROUND_BIAS)) >> Q30_SHIFT);
         sign7_ff <= sign6_ff;
         q8_ff    <= TERM_W'(div3_prod >> DIV3_S);
         sign8_ff <= sign7_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red           = red_ff;
   assign rsp_green         = green_ff;
   assign rsp_blue          = blue_ff;
   assign rsp_range_warning = rsp_warn_ff;

endmodule

>>> rtl/hci_cos_rom.sv
// ----------------------------------------------------------------------------
// HCI quarter-wave cosine ROM
// Q2.30 cosine over one quarter turn, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module hci_cos_rom #(
   parameter int QUARTER = 1440,
   localparam int ADDR_W = $clog2(QUARTER + 1)
) (
   input  logic                             clock,
   input  logic [ADDR_W-1:0]                addr,
   output logic signed [hci_pkg::COS_W-1:0] data
);
   import hci_pkg::*;

   typedef logic signed [COS_W-1:0] rom_type [QUARTER+1];

   // truncating Horner series on the folded angle
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] p;
      for (int u = 0; u <= QUARTER; u++) begin
         x  = (64'(u) * HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
         x2 = (x * x) >> Q30_SHIFT;
         t  = Q30_ONE;
         for (int k = 0; k < SERIES_LEN; k++) begin
            p = (x2 * t) >> Q30_SHIFT;
            t = Q30_ONE - p / 64'(SERIES_DIV[k]);
         end
         p      = (x2 * t) >> Q30_SHIFT;
         rom[u] = COS_W'(Q30_ONE - p / 64'd2);
      end
      return rom;
   endfunction

   localparam rom_type COS_ROM = build_rom();

   logic signed [COS_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= COS_ROM[addr];
   end

   assign data = data_ff;

endmodule

>>> rtl/hci_checker.sv
// ----------------------------------------------------------------------------
// HCI to RGB converter port checker
// Timing and value checks on the converter ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "hci_to_rgb_convert_core_defines.svh"

module hci_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [hci_pkg::IN_W-1:0]          req_hue,
   input logic [hci_pkg::IN_W-1:0]          req_chroma,
   input logic [hci_pkg::IN_W-1:0]          req_intensity,
   input logic                              rsp_valid,
   input logic signed [hci_pkg::OUT_W-1:0]  rsp_red,
   input logic signed [hci_pkg::OUT_W-1:0]  rsp_green,
   input logic signed [hci_pkg::OUT_W-1:0]  rsp_blue,
   input logic                              rsp_range_warning
);
   import hci_pkg::*;

   logic [IN_W-1:0] unused_hue;
   assign unused_hue = req_hue;

   // every strobe comes from a transfer a fixed latency back
   `HCI_ASSERT_IMPLY(a_rsp_has_source, clock, reset, rsp_valid, $past(start && !busy, LATENCY))

   // every transfer yields its strobe
   `HCI_ASSERT_LATER(a_rsp_follows, clock, reset, start && !busy, LATENCY, rsp_valid)

   // zero chroma leaves every channel at the intensity
   `HCI_ASSERT_IMPLY(a_gray_pixel, clock, reset, rsp_valid && ($past(req_chroma, LATENCY) == '0), (rsp_red == OUT_W'($past(req_intensity, LATENCY))) && (rsp_green == rsp_red) && (rsp_blue == rsp_red))

   // chroma or intensity above one raises the warning
   `HCI_ASSERT_LATER(a_warn_raised, clock, reset, start && !busy && ((req_chroma > ONE_VALUE) || (req_intensity > ONE_VALUE)), LATENCY, rsp_range_warning)

endmodule

bind hci_to_rgb_convert_core hci_checker u_hci_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_hue           (req_hue),
   .req_chroma        (req_chroma),
   .req_intensity     (req_intensity),
   .rsp_valid         (rsp_valid),
   .rsp_red           (rsp_red),
   .rsp_green         (rsp_green),
   .rsp_blue          (rsp_blue),
   .rsp_range_warning (rsp_range_warning)
);

>>> bench/hci_to_rgb_convert_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HCI to RGB converter result checker
// Watches the pixel and result channels, works out the expected RGB for each
// pixel transfer and compares every result strobe, field by field, in order.
// ----------------------------------------------------------------------------
module hci_to_rgb_convert_checker #(
   parameter int HUE_STEPS_PER_DEGREE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [hci_pkg::IN_W-1:0]          req_hue,
   input  logic [hci_pkg::IN_W-1:0]          req_chroma,
   input  logic [hci_pkg::IN_W-1:0]          req_intensity,
   input  logic                              rsp_valid,
   input  logic signed [hci_pkg::OUT_W-1:0]  rsp_red,
   input  logic signed [hci_pkg::OUT_W-1:0]  rsp_green,
   input  logic signed [hci_pkg::OUT_W-1:0]  rsp_blue,
   input  logic                              rsp_range_warning,
   output int                                fail_count,
   output int                                pending,
   output int                                checked_count,
   output int                                warn_count
);
   import hci_pkg::*;

   localparam int unsigned FULL_TURN    = 360 * HUE_STEPS_PER_DEGREE;
   localparam int unsigned THIRD_TURN   = 120 * HUE_STEPS_PER_DEGREE;
   localparam int unsigned QUARTER_TURN = 90 * HUE_STEPS_PER_DEGREE;

   typedef struct {
      logic signed [OUT_W-1:0] red;
      logic signed [OUT_W-1:0] green;
      logic signed [OUT_W-1:0] blue;
      logic                    range_warning;
   } rgb_pixel_type;

   rgb_pixel_type expected_pixels[$];
   rgb_pixel_type want;
   int         mismatches = 0;
   int         results_seen = 0;
   int         warnings_seen = 0;

   // Q30 cosine of an angle index in [0, FULL_TURN)
   function automatic longint cos_q30(input int unsigned angle);
      int unsigned quadrant;
      int unsigned rem;
      int unsigned u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] p;
      longint      c;
      int          i;
      quadrant = (angle / QUARTER_TURN) & 3;
      rem      = angle % QUARTER_TURN;
      // fold onto the first quarter wave
      u  = quadrant[0] ? QUARTER_TURN - rem : rem;
      x  = (64'(u) * HALF_PI_Q30 + 64'(QUARTER_TURN / 2)) / 64'(QUARTER_TURN);
      x2 = (x * x) >> Q30_SHIFT;
      t  = Q30_ONE;
      for (i = 0; i < SERIES_LEN; i++) begin
         p = (x2 * t) >> Q30_SHIFT;
         t = Q30_ONE - p / 64'(SERIES_DIV[i]);
      end
      c = longint'(Q30_ONE) - longint'(((x2 * t) >> Q30_SHIFT) / 64'd2);
      return (quadrant == 1 || quadrant == 2) ? -c : c;
   endfunction

   function automatic logic [OUT_W-1:0] channel_value(input int unsigned angle,
                                                      input int unsigned chroma,
                                                      input int unsigned intensity);
      longint      num;
      logic [63:0] mag;
      logic [63:0] q;
      longint      v;
      num = 2 * longint'(chroma) * cos_q30(angle);
      mag = (num < 0) ? -num : num;
      // round half away from zero on the magnitude
      q   = (mag + ROUND_BIAS) / (64'd3 << Q30_SHIFT);
      v   = longint'(intensity) + ((num < 0) ? -longint'(q) : longint'(q));
      return v[OUT_W-1:0];
   endfunction

   function automatic rgb_pixel_type predict_rgb(input logic [IN_W-1:0] hue,
                                                 input logic [IN_W-1:0] chroma,
                                                 input logic [IN_W-1:0] intensity);
      rgb_pixel_type px;
      int unsigned   h;
      int unsigned   c;
      int unsigned   i;
      h = int'(hue) % FULL_TURN;
      c = 32'(chroma);
      i = 32'(intensity);
      px.red   = channel_value(h, c, i);
      px.green = channel_value((h + FULL_TURN - THIRD_TURN) % FULL_TURN, c, i);
      px.blue  = channel_value((h + THIRD_TURN) % FULL_TURN, c, i);
      px.range_warning = (hue > FULL_TURN) || (chroma > ONE_VALUE)
                         || (intensity > ONE_VALUE);
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH result %0d: %s", results_seen, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         // check the result first: a pixel taken at this edge cannot be it
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result strobe with no pixel outstanding (red %0d)",
                                         rsp_red));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_red !== want.red)
                  report_mismatch($sformatf("red %0d, expected %0d", rsp_red, want.red));
               if (rsp_green !== want.green)
                  report_mismatch($sformatf("green %0d, expected %0d",
                                            rsp_green, want.green));
               if (rsp_blue !== want.blue)
                  report_mismatch($sformatf("blue %0d, expected %0d", rsp_blue, want.blue));
               if (rsp_range_warning !== want.range_warning)
                  report_mismatch($sformatf("range_warning %b, expected %b",
                                            rsp_range_warning, want.range_warning));
               if (want.range_warning)
                  warnings_seen++;
            end
            results_seen++;
         end
         if (start && !busy)
            expected_pixels.push_back(predict_rgb(req_hue, req_chroma, req_intensity));
      end
      fail_count    <= mismatches;
      pending       <= expected_pixels.size();
      checked_count <= results_seen;
      warn_count    <= warnings_seen;
   end

endmodule

>>> bench/hci_to_rgb_convert_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HCI to RGB converter testbench
// Drives directed corner pixels and then random pixels through the converter
// under three sender gap profiles; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module hci_to_rgb_convert_core_tb;
   import hci_pkg::*;

   localparam int HUE_STEPS     = 16;
   localparam int FULL_TURN     = 360 * HUE_STEPS;
   localparam int PIXELS_PER_RUN = 340;
   localparam int CYCLE_LIMIT   = 200000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [IN_W-1:0]           req_hue;
   logic [IN_W-1:0]           req_chroma;
   logic [IN_W-1:0]           req_intensity;
   logic                      rsp_valid;
   logic signed [OUT_W-1:0]   rsp_red;
   logic signed [OUT_W-1:0]   rsp_green;
   logic signed [OUT_W-1:0]   rsp_blue;
   logic                      rsp_range_warning;

   int fail_count;
   int pending;
   int checked_count;
   int warn_count;
   int cycle_count = 0;
   int idle_pct = 0;
   int phase_idle[3] = '{6, 57, 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hci_to_rgb_convert_core #(
      .HUE_STEPS_PER_DEGREE(HUE_STEPS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_hue           (req_hue),
      .req_chroma        (req_chroma),
      .req_intensity     (req_intensity),
      .rsp_valid         (rsp_valid),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_range_warning (rsp_range_warning)
   );

   hci_to_rgb_convert_checker #(
      .HUE_STEPS_PER_DEGREE(HUE_STEPS)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_hue           (req_hue),
      .req_chroma        (req_chroma),
      .req_intensity     (req_intensity),
      .rsp_valid         (rsp_valid),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_range_warning (rsp_range_warning),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked_count     (checked_count),
      .warn_count        (warn_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("Some tests failed");
         $finish;
      end
   end

   // drop start for random gaps, then hold the pixel until its transfer
   task automatic send_pixel(input logic [IN_W-1:0] hue,
                             input logic [IN_W-1:0] chroma,
                             input logic [IN_W-1:0] intensity);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_hue       <= hue;
      req_chroma    <= chroma;
      req_intensity <= intensity;
      do @(posedge clock); while (busy);
   endtask

   // the pending count is registered, so look only after the next edge
   task automatic wait_drained;
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // mostly in range, some near grid points, some anywhere in the field
   function automatic logic [IN_W-1:0] pick_level(input int unsigned top,
                                                  input int unsigned grain);
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return IN_W'($urandom_range(top));
         6, 7:             return IN_W'($urandom_range(top) / grain * grain
                                        + $urandom_range(2) - 1);
         default:          return IN_W'($urandom);
      endcase
   endfunction

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_hue       <= '0;
      req_chroma    <= '0;
      req_intensity <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      idle_pct = phase_idle[0];
      // field extremes, quadrant edges, exactly a full turn and past it
      send_pixel(IN_W'(0), IN_W'(0), IN_W'(0));
      send_pixel(IN_W'(0), ONE_VALUE, ONE_VALUE);
      send_pixel(IN_W'(0), 13'h1fff, 13'h1fff);
      send_pixel(IN_W'(0), ONE_VALUE + IN_W'(1), IN_W'(0));
      send_pixel(IN_W'(0), IN_W'(0), ONE_VALUE + IN_W'(1));
      send_pixel(IN_W'(FULL_TURN), ONE_VALUE, ONE_VALUE);
      send_pixel(IN_W'(FULL_TURN + 1), ONE_VALUE, IN_W'(0));
      send_pixel(13'h1fff, ONE_VALUE, IN_W'(2048));
      send_pixel(13'h1fff, 13'h1fff, IN_W'(0));
      send_pixel(IN_W'(FULL_TURN - 1), ONE_VALUE, IN_W'(0));
      send_pixel(IN_W'(FULL_TURN / 4), ONE_VALUE, IN_W'(0));
      send_pixel(IN_W'(FULL_TURN / 4 - 1), 13'h1fff, IN_W'(0));
      send_pixel(IN_W'(FULL_TURN / 4 + 1), 13'h1fff, IN_W'(0));
      send_pixel(IN_W'(FULL_TURN / 2), ONE_VALUE, IN_W'(0));
      send_pixel(IN_W'(FULL_TURN * 3 / 4), ONE_VALUE, IN_W'(1));
      send_pixel(IN_W'(FULL_TURN / 3), ONE_VALUE, ONE_VALUE);
      send_pixel(IN_W'(FULL_TURN * 2 / 3), ONE_VALUE, ONE_VALUE);
      send_pixel(IN_W'(FULL_TURN / 12), IN_W'(1), IN_W'(0));
      send_pixel(IN_W'(1), 13'h1fff, 13'h1fff);
      send_pixel(IN_W'(FULL_TURN + FULL_TURN / 4), ONE_VALUE, IN_W'(2048));

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = phase_idle[phase];
         repeat (PIXELS_PER_RUN)
            send_pixel(pick_level(FULL_TURN, FULL_TURN / 24),
                       pick_level(32'(ONE_VALUE), 32'(ONE_VALUE) / 4),
                       pick_level(32'(ONE_VALUE), 32'(ONE_VALUE) / 4));
         // hold off the next profile until every result is back
         wait_drained();
      end

      repeat (LATENCY + 4) @(posedge clock);
      $display("Checked %0d pixels (%0d out of range) across directed corners and",
               checked_count, warn_count);
      $display("random traffic with sparse, heavy and no sender gaps");
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
